/* sv/npoc_pkg.sv */
// Shared types, constants and codes of the nearest point offset correction block.
`timescale 1ns / 1ps
package npoc_pkg;

	localparam int MAX_ENTRIES = 64;
	localparam int COORD_BITS  = 32;
	localparam int FIELD_W     = 32;
	localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
	localparam int DIST_W      = 2 * COORD_BITS + 1;

	typedef logic signed [FIELD_W-1:0]    field_t;
	typedef logic signed [COORD_BITS-1:0] coord_t;

	localparam coord_t COORD_MAX = {1'b0, {(COORD_BITS - 1){1'b1}}};
	localparam coord_t COORD_MIN = {1'b1, {(COORD_BITS - 1){1'b0}}};

	typedef enum logic {
		CMD_LOAD    = 1'b0,
		CMD_CORRECT = 1'b1
	} cmd_t;

	typedef enum logic {
		STATUS_OK   = 1'b0,
		STATUS_FULL = 1'b1
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FETCH,
		ST_APPLY
	} state_t;

	typedef struct packed {
		coord_t ex;
		coord_t ey;
		coord_t edx;
		coord_t edy;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic             valid;
		logic             axis;
		logic             last;
		logic [IDX_W-1:0] idx;
	} op_t;

endpackage

/* sv/npoc_req_if.sv */
// Request channel interface carrying one command transaction.
`timescale 1ns / 1ps
interface npoc_req_if;
	import npoc_pkg::*;

	logic   valid;
	logic   ready;
	logic   command;
	field_t x_coord;
	field_t y_coord;
	field_t offset_x;
	field_t offset_y;

	modport source (output valid, command, x_coord, y_coord, offset_x, offset_y, input ready);
	modport sink (input valid, command, x_coord, y_coord, offset_x, offset_y, output ready);
endinterface

/* sv/npoc_rsp_if.sv */
// Response channel interface carrying one result transaction.
`timescale 1ns / 1ps
interface npoc_rsp_if;
	import npoc_pkg::*;

	logic   valid;
	logic   ready;
	field_t x_result;
	field_t y_result;
	logic   applied;
	logic   status;

	modport source (output valid, x_result, y_result, applied, status, input ready);
	modport sink (input valid, x_result, y_result, applied, status, output ready);
endinterface

/* sv/npoc_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
module npoc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

/* sv/npoc_dist_unit.sv */
// Shared subtract, square and accumulate pipeline that forms squared distances.
`timescale 1ns / 1ps
module npoc_dist_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  npoc_pkg::op_t             op,
	input  npoc_pkg::coord_t          ent_x,
	input  npoc_pkg::coord_t          ent_y,
	input  npoc_pkg::coord_t          px,
	input  npoc_pkg::coord_t          py,
	output npoc_pkg::op_t             res_tag,
	output logic [npoc_pkg::DIST_W-1:0] res_dist
);
	import npoc_pkg::*;

	op_t tag_s1, tag_s2, tag_s3, tag_s4;
	logic [COORD_BITS-1:0]   mag_s2;
	logic [2*COORD_BITS-1:0] sq_s3;
	logic [2*COORD_BITS-1:0] part_q;
	logic [DIST_W-1:0]       dist_s4;

	logic signed [COORD_BITS:0] sa, sb, dif;
	logic [COORD_BITS:0]        mag_full;

	always_comb begin
		sa       = (COORD_BITS + 1)'(tag_s1.axis ? py : px);
		sb       = (COORD_BITS + 1)'(tag_s1.axis ? ent_y : ent_x);
		dif      = sa - sb;
		mag_full = dif[COORD_BITS] ? (-dif) : dif;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			tag_s3 <= '0;
			tag_s4 <= '0;
		end else begin
			tag_s1 <= op;
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
			tag_s4 <= '{valid: tag_s3.valid && tag_s3.axis, axis: tag_s3.axis,
				last: tag_s3.last, idx: tag_s3.idx};
		end
	end

	always_ff @(posedge clk) begin
		mag_s2 <= mag_full[COORD_BITS-1:0];
		sq_s3  <= mag_s2 * mag_s2;
		if (tag_s3.valid && !tag_s3.axis) begin
			part_q <= sq_s3;
		end
		dist_s4 <= {1'b0, part_q} + {1'b0, sq_s3};
	end

	assign res_tag  = tag_s4;
	assign res_dist = dist_s4;
endmodule

/* sv/nearest_point_offset_correction_core.sv */
// Top level of the nearest point offset correction block.
// A load or a correct on an empty table gives its result in the cycle after acceptance.
// A correct scans every table entry, then fetches the nearest offset; the shared squaring unit takes
// one axis of one entry per cycle, and the table RAM is read once per axis and once more.
// A request is accepted in the cycle the last result is taken, so unstalled loads run one per cycle.
// Reset clears the entry count and the control state; table contents are not cleared.
`timescale 1ns / 1ps
module nearest_point_offset_correction_core (
	input logic        clk,
	input logic        arst_n,
	npoc_req_if.sink   request,
	npoc_rsp_if.source response
);
	import npoc_pkg::*;

	state_t state_q, state_d;
	logic [CNT_W-1:0]  count_q, count_m1;
	logic [IDX_W-1:0]  idx_q, best_q, raddr;
	logic              axis_q, first_q;
	coord_t            px_q, py_q;
	logic [DIST_W-1:0] best_dist_q;
	op_t               op, dres_tag;
	logic [DIST_W-1:0] dres_dist;
	entry_t            rd_entry;
	logic [ENTRY_W-1:0] rd_data;
	entry_t            wr_entry;
	logic              accept, is_load, full, we;
	coord_t            in_x, in_y;
	logic              out_valid_q;
	field_t            x_res_q, y_res_q;
	logic              applied_q, status_q;

	function automatic coord_t sat_add(input coord_t a, input coord_t b);
		logic signed [COORD_BITS:0] s;
		s = (COORD_BITS + 1)'(a) + (COORD_BITS + 1)'(b);
		if (s[COORD_BITS] != s[COORD_BITS-1]) begin
			return s[COORD_BITS] ? COORD_MIN : COORD_MAX;
		end
		return coord_t'(s[COORD_BITS-1:0]);
	endfunction

	assign in_x     = request.x_coord[COORD_BITS-1:0];
	assign in_y     = request.y_coord[COORD_BITS-1:0];
	assign accept   = request.valid && request.ready;
	assign is_load  = (request.command == CMD_LOAD);
	assign full     = (count_q == CNT_W'(MAX_ENTRIES));
	assign we       = accept && is_load && !full;
	assign count_m1 = count_q - CNT_W'(1);
	assign rd_entry = entry_t'(rd_data);

	assign wr_entry.ex  = in_x;
	assign wr_entry.ey  = in_y;
	assign wr_entry.edx = request.offset_x[COORD_BITS-1:0];
	assign wr_entry.edy = request.offset_y[COORD_BITS-1:0];

	assign request.ready     = (state_q == ST_IDLE) && (!out_valid_q || response.ready);
	assign response.valid    = out_valid_q;
	assign response.x_result = x_res_q;
	assign response.y_result = y_res_q;
	assign response.applied  = applied_q;
	assign response.status   = status_q;

	npoc_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(MAX_ENTRIES)
	) u_table (
		.clk   (clk),
		.we    (we),
		.waddr (count_q[IDX_W-1:0]),
		.wdata (ENTRY_W'(wr_entry)),
		.raddr (raddr),
		.rdata (rd_data)
	);

	npoc_dist_unit u_dist (
		.clk      (clk),
		.arst_n   (arst_n),
		.op       (op),
		.ent_x    (rd_entry.ex),
		.ent_y    (rd_entry.ey),
		.px       (px_q),
		.py       (py_q),
		.res_tag  (dres_tag),
		.res_dist (dres_dist)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		op      = '0;
		raddr   = idx_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && !is_load && (count_q != '0)) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				op.valid = 1'b1;
				op.axis  = axis_q;
				op.idx   = idx_q;
				op.last  = axis_q && (idx_q == '0);
				if (op.last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (dres_tag.valid && dres_tag.last) begin
					state_d = ST_FETCH;
				end
			end
			ST_FETCH: begin
				raddr   = best_q;
				state_d = ST_APPLY;
			end
			ST_APPLY: begin
				raddr   = best_q;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			idx_q       <= '0;
			axis_q      <= 1'b0;
			first_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (we) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (accept) begin
				idx_q   <= count_m1[IDX_W-1:0];
				axis_q  <= 1'b0;
				first_q <= 1'b1;
			end else if (state_q == ST_SCAN) begin
				axis_q <= ~axis_q;
				if (axis_q) begin
					idx_q <= idx_q - IDX_W'(1);
				end
			end
			if (dres_tag.valid) begin
				if (first_q || (dres_dist < best_dist_q)) begin
					first_q <= 1'b0;
				end
			end
			if ((accept && (is_load || (count_q == '0))) || (state_q == ST_APPLY)) begin
				out_valid_q <= 1'b1;
			end else if (response.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_q      <= in_x;
			py_q      <= in_y;
			x_res_q   <= FIELD_W'(in_x);
			y_res_q   <= FIELD_W'(in_y);
			applied_q <= 1'b0;
			status_q  <= (is_load && full) ? STATUS_FULL : STATUS_OK;
		end else if (state_q == ST_APPLY) begin
			x_res_q   <= FIELD_W'(sat_add(px_q, rd_entry.edx));
			y_res_q   <= FIELD_W'(sat_add(py_q, rd_entry.edy));
			applied_q <= 1'b1;
			status_q  <= STATUS_OK;
		end
		if (dres_tag.valid && (first_q || (dres_dist < best_dist_q))) begin
			best_dist_q <= dres_dist;
			best_q      <= dres_tag.idx;
		end
	end

	a_count_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_ENTRIES))
		else $error("Entry count exceeds table capacity.");

	a_last_to_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		(dres_tag.valid && dres_tag.last) |=> (state_q == ST_FETCH))
		else $error("Final distance did not lead to the offset fetch.");

	a_applied_not_refused: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(applied_q && (status_q == STATUS_FULL)))
		else $error("A result is both applied and refused.");

	a_scan_has_entries: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (count_q != '0))
		else $error("Scan started on an empty table.");
endmodule

/* sim/tb_nearest_point_offset_correction_core.sv */
// Self-checking testbench of the nearest point offset correction core with a built-in predictor.
`timescale 1ns / 1ps
module tb_nearest_point_offset_correction_core;
	import npoc_pkg::*;

	localparam int RAND_ITEMS  = 800;
	localparam int CYCLE_LIMIT = 900000;
	localparam int HOLD_OFF    = 500;
	localparam int TAIL_CYCLES = 2 * (2 * MAX_ENTRIES + 7);

	typedef struct {
		cmd_t   cmd;
		field_t x;
		field_t y;
		field_t ox;
		field_t oy;
	} npoc_item_t;

	typedef struct {
		field_t  xr;
		field_t  yr;
		logic    applied;
		status_t status;
	} npoc_result_t;

	typedef struct {
		npoc_item_t   item;
		bit           typed;
		npoc_result_t res;
	} stim_row_t;

	logic clk;
	logic arst_n;

	npoc_req_if req_if ();
	npoc_rsp_if rsp_if ();

	nearest_point_offset_correction_core dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (req_if),
		.response(rsp_if)
	);

	field_t tbl_x  [MAX_ENTRIES];
	field_t tbl_y  [MAX_ENTRIES];
	field_t tbl_dx [MAX_ENTRIES];
	field_t tbl_dy [MAX_ENTRIES];
	int     tbl_count;

	npoc_result_t answer_q [$];
	stim_row_t    stim_tab [$];
	int           err_count;
	int           sent_cnt;
	int           rcv_cnt;
	int           cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		err_count++;
	endtask

	function automatic logic [64:0] sq_distance(input field_t px, input field_t py, input int k);
		logic [32:0] ddx;
		logic [32:0] ddy;
		logic [63:0] ax;
		logic [63:0] ay;
		ddx = {px[31], px} - {tbl_x[k][31], tbl_x[k]};
		ddy = {py[31], py} - {tbl_y[k][31], tbl_y[k]};
		if (ddx[32])
			ddx = -ddx;
		if (ddy[32])
			ddy = -ddy;
		ax = ddx;
		ay = ddy;
		return {1'b0, ax * ax} + {1'b0, ay * ay};
	endfunction

	function automatic field_t saturate(input logic [32:0] s);
		if (s[32] != s[31])
			return s[32] ? COORD_MIN : COORD_MAX;
		return s[31:0];
	endfunction

	function automatic npoc_result_t predict_result(input npoc_item_t it);
		npoc_result_t r;
		logic [64:0]  best_d;
		logic [64:0]  d;
		int           best;
		r.xr      = it.x;
		r.yr      = it.y;
		r.applied = 1'b0;
		r.status  = STATUS_OK;
		if (it.cmd == CMD_LOAD) begin
			if (tbl_count < MAX_ENTRIES) begin
				tbl_x[tbl_count]  = it.x;
				tbl_y[tbl_count]  = it.y;
				tbl_dx[tbl_count] = it.ox;
				tbl_dy[tbl_count] = it.oy;
				tbl_count++;
			end else begin
				r.status = STATUS_FULL;
			end
		end else if (tbl_count > 0) begin
			best   = 0;
			best_d = sq_distance(it.x, it.y, 0);
			for (int i = 1; i < tbl_count; i++) begin
				d = sq_distance(it.x, it.y, i);
				if (d <= best_d) begin
					best_d = d;
					best   = i;
				end
			end
			r.xr      = saturate({it.x[31], it.x} + {tbl_dx[best][31], tbl_dx[best]});
			r.yr      = saturate({it.y[31], it.y} + {tbl_dy[best][31], tbl_dy[best]});
			r.applied = 1'b1;
		end
		return r;
	endfunction

	function automatic field_t pick_coord();
		case ($urandom_range(0, 9))
			0: return COORD_MAX;
			1: return COORD_MIN;
			2: return '0;
			3: return field_t'($urandom_range(0, 200)) - 100;
			default: return field_t'($urandom);
		endcase
	endfunction

	function automatic void add_row(input cmd_t c, input field_t x, input field_t y,
			input field_t ox, input field_t oy, input bit typed, input field_t xr,
			input field_t yr, input logic ap, input status_t st);
		stim_row_t row;
		row.item.cmd   = c;
		row.item.x     = x;
		row.item.y     = y;
		row.item.ox    = ox;
		row.item.oy    = oy;
		row.typed      = typed;
		row.res.xr     = xr;
		row.res.yr     = yr;
		row.res.applied = ap;
		row.res.status = st;
		stim_tab.push_back(row);
	endfunction

	task automatic send_item(input npoc_item_t it, input bit typed, input npoc_result_t typed_res);
		int           gap;
		npoc_result_t res;
		gap = ((sent_cnt % 160) >= 130) ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_if.valid    <= 1'b1;
		req_if.command  <= it.cmd;
		req_if.x_coord  <= it.x;
		req_if.y_coord  <= it.y;
		req_if.offset_x <= it.ox;
		req_if.offset_y <= it.oy;
		do @(posedge clk); while (req_if.ready !== 1'b1);
		res = predict_result(it);
		answer_q.push_back(typed ? typed_res : res);
		sent_cnt++;
	endtask

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		int           stall;
		npoc_result_t want;
		rsp_if.ready <= 1'b0;
		do @(posedge clk); while (arst_n !== 1'b1);
		forever begin
			stall = ((rcv_cnt % 160) < 30) ? 0 : $urandom_range(0, 14);
			if (rcv_cnt == 150)
				stall = HOLD_OFF;
			if (stall > 0) begin
				rsp_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_if.ready <= 1'b1;
			do @(posedge clk); while (rsp_if.valid !== 1'b1);
			rcv_cnt++;
			if (answer_q.size() == 0) begin
				report_mismatch("result transaction with no expected result");
			end else begin
				want = answer_q.pop_front();
				if (rsp_if.x_result !== want.xr)
					report_mismatch($sformatf("x_result got %0d expected %0d",
						rsp_if.x_result, want.xr));
				if (rsp_if.y_result !== want.yr)
					report_mismatch($sformatf("y_result got %0d expected %0d",
						rsp_if.y_result, want.yr));
				if (rsp_if.applied !== want.applied)
					report_mismatch($sformatf("applied got %b expected %b",
						rsp_if.applied, want.applied));
				if (rsp_if.status !== want.status)
					report_mismatch($sformatf("status got %b expected %b",
						rsp_if.status, want.status));
			end
		end
	end

	initial begin
		npoc_item_t   it;
		npoc_result_t none;
		int           k;
		int           load_pct;
		err_count = 0;
		sent_cnt  = 0;
		rcv_cnt   = 0;
		cycles    = 0;
		tbl_count = 0;
		none      = '{xr: '0, yr: '0, applied: 1'b0, status: STATUS_OK};
		arst_n          <= 1'b0;
		req_if.valid    <= 1'b0;
		req_if.command  <= CMD_LOAD;
		req_if.x_coord  <= '0;
		req_if.y_coord  <= '0;
		req_if.offset_x <= '0;
		req_if.offset_y <= '0;

		// Empty table first, then single entries, extremes, saturation and distance ties.
		add_row(CMD_CORRECT, COORD_MAX, COORD_MAX, 5, 6, 1, COORD_MAX, COORD_MAX, 0, STATUS_OK);
		add_row(CMD_CORRECT, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MIN, 1,
			COORD_MIN, COORD_MIN, 0, STATUS_OK);
		add_row(CMD_CORRECT, 0, 0, -1, -1, 1, 0, 0, 0, STATUS_OK);
		add_row(CMD_LOAD, 0, 0, 100, -100, 1, 0, 0, 0, STATUS_OK);
		add_row(CMD_CORRECT, 5, 5, 0, 0, 1, 105, -95, 1, STATUS_OK);
		add_row(CMD_LOAD, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 1,
			COORD_MAX, COORD_MAX, 0, STATUS_OK);
		add_row(CMD_CORRECT, COORD_MAX - 1, COORD_MAX, 0, 0, 1, COORD_MAX, COORD_MAX, 1, STATUS_OK);
		add_row(CMD_LOAD, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, 1,
			COORD_MIN, COORD_MIN, 0, STATUS_OK);
		add_row(CMD_CORRECT, COORD_MIN, COORD_MIN + 2, 0, 0, 1, COORD_MIN, COORD_MIN, 1, STATUS_OK);
		add_row(CMD_LOAD, 0, 0, -7, 9, 1, 0, 0, 0, STATUS_OK);
		add_row(CMD_CORRECT, 0, 0, 0, 0, 0, 0, 0, 0, STATUS_OK);
		add_row(CMD_CORRECT, 1000, -1000, -1, -1, 0, 0, 0, 0, STATUS_OK);
		add_row(CMD_CORRECT, COORD_MIN, COORD_MAX, 0, 0, 0, 0, 0, 0, STATUS_OK);
		add_row(CMD_CORRECT, COORD_MAX, COORD_MIN, 0, 0, 0, 0, 0, 0, STATUS_OK);
		add_row(CMD_LOAD, COORD_MIN, COORD_MAX, 1, 1, 1, COORD_MIN, COORD_MAX, 0, STATUS_OK);
		add_row(CMD_CORRECT, COORD_MIN, COORD_MAX, 0, 0, 0, 0, 0, 0, STATUS_OK);
		add_row(CMD_LOAD, 50, 50, COORD_MIN, COORD_MAX, 1, 50, 50, 0, STATUS_OK);
		add_row(CMD_CORRECT, 48, 48, 0, 0, 0, 0, 0, 0, STATUS_OK);
		add_row(CMD_LOAD, 46, 46, 3, 4, 1, 46, 46, 0, STATUS_OK);
		add_row(CMD_CORRECT, 48, 48, -1, -1, 0, 0, 0, 0, STATUS_OK);
		add_row(CMD_LOAD, -1, -1, -1, -1, 1, -1, -1, 0, STATUS_OK);
		add_row(CMD_CORRECT, -2, -1, COORD_MAX, COORD_MAX, 0, 0, 0, 0, STATUS_OK);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_tab[i])
			send_item(stim_tab[i].item, stim_tab[i].typed, stim_tab[i].res);

		for (int n = 0; n < RAND_ITEMS; n++) begin
			load_pct = (tbl_count >= MAX_ENTRIES) ? 15 : 30;
			it.ox = pick_coord();
			it.oy = pick_coord();
			k = $urandom_range(0, tbl_count - 1);
			if ($urandom_range(0, 99) < load_pct) begin
				it.cmd = CMD_LOAD;
				case ($urandom_range(0, 3))
					0: begin
						it.x = tbl_x[k];
						it.y = tbl_y[k];
					end
					1: begin
						it.x = field_t'($urandom_range(0, 400)) - 200;
						it.y = field_t'($urandom_range(0, 400)) - 200;
					end
					default: begin
						it.x = pick_coord();
						it.y = pick_coord();
					end
				endcase
			end else begin
				it.cmd = CMD_CORRECT;
				case ($urandom_range(0, 9))
					0, 1: begin
						it.x = tbl_x[k];
						it.y = tbl_y[k];
					end
					2, 3, 4: begin
						it.x = tbl_x[k] + field_t'($urandom_range(0, 6)) - 3;
						it.y = tbl_y[k] + field_t'($urandom_range(0, 6)) - 3;
					end
					5: begin
						it.x = field_t'($urandom_range(0, 400)) - 200;
						it.y = field_t'($urandom_range(0, 400)) - 200;
					end
					default: begin
						it.x = pick_coord();
						it.y = pick_coord();
					end
				endcase
			end
			send_item(it, 1'b0, none);
		end
		req_if.valid <= 1'b0;

		while (answer_q.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (err_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
